// ===== sv/greedy_iou_box_suppression_defines.svh =====
// assertion macros for the greedy iou box suppression block
`ifndef GREEDY_IOU_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_IOU_BOX_SUPPRESSION_DEFINES_SVH

// same-cycle implication, checked on clock, masked during reset
`define GIBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on clock, masked during reset
`define GIBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/gibs_pkg.sv =====
// shared types and constants of the greedy iou box suppression block
package gibs_pkg;

   localparam int MAX_KEPT   = 64;
   localparam int COORD_BITS = 12;
   localparam int IDX_BITS   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_BITS   = $clog2(MAX_KEPT + 1);
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int AREA_BITS  = 2 * COORD_BITS;
   localparam int INTER_BITS = 2 * EDGE_BITS;
   localparam int UNION_BITS = AREA_BITS + 1;
   localparam int THR_BITS   = 10;
   localparam int PROD_BITS  = INTER_BITS + THR_BITS;
   localparam int PIPE_DEPTH = 6;
   localparam int PERMILLE   = 1000;
   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(300);

   typedef struct packed {
      logic [COORD_BITS-1:0] box_x;
      logic [COORD_BITS-1:0] box_y;
      logic [COORD_BITS-1:0] box_width;
      logic [COORD_BITS-1:0] box_height;
      logic                  frame_end;
   } req_type;

   typedef struct packed {
      logic keep;
      logic not_stored;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } box_type;

   typedef struct packed {
      logic                load;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } sts_type;

endpackage

// ===== sv/gibs_datapath.sv =====
// box store and pipelined iou overlap test
module gibs_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  gibs_pkg::req_type              req_data,
   input  logic                           csr_wr_en,
   input  logic [gibs_pkg::THR_BITS-1:0]  csr_wr_data,
   input  gibs_pkg::cmd_type              cmd,
   output gibs_pkg::sts_type              sts
);
   import gibs_pkg::*;

   box_type mem [MAX_KEPT];

   logic [THR_BITS-1:0]   thr_ff;
   logic [PIPE_DEPTH-1:0] v_ff;
   logic [PIPE_DEPTH-1:0] v_in;
   logic                  hit_ff;

   box_type               p_ff;
   logic [AREA_BITS-1:0]  pa_ff;
   box_type               q_ff;

   logic [EDGE_BITS-1:0]  p_right, p_bottom, q_right, q_bottom;
   logic [EDGE_BITS-1:0]  s1_left_ff, s1_top_ff, s1_right_ff, s1_bottom_ff;
   logic [COORD_BITS-1:0] s1_qw_ff, s1_qh_ff;
   logic [EDGE_BITS-1:0]  s2_iw_ff, s2_ih_ff;
   logic [AREA_BITS-1:0]  s2_qa_ff, s3_qa_ff;
   logic [INTER_BITS-1:0] s3_inter_ff;
   logic [UNION_BITS-1:0] s4_union_ff;
   logic [PROD_BITS-1:0]  s4_inter_k_ff, s5_inter_k_ff, s5_thr_union_ff;
   logic                  s5_union_nz_ff;

   assign v_in = {v_ff[PIPE_DEPTH-2:0], cmd.rd_en};

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         v_ff   <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         v_ff <= v_in;
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (v_ff[PIPE_DEPTH-1] && s5_union_nz_ff
                      && (s5_inter_k_ff > s5_thr_union_ff)) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // new box and its area
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ff.x <= req_data.box_x;
         p_ff.y <= req_data.box_y;
         p_ff.w <= req_data.box_width;
         p_ff.h <= req_data.box_height;
         pa_ff  <= AREA_BITS'(req_data.box_width) * AREA_BITS'(req_data.box_height);
      end
   end

   // kept box store
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= p_ff;
      end
      if (cmd.rd_en) begin
         q_ff <= mem[cmd.rd_addr];
      end
   end

   assign p_right  = EDGE_BITS'(p_ff.x) + EDGE_BITS'(p_ff.w);
   assign p_bottom = EDGE_BITS'(p_ff.y) + EDGE_BITS'(p_ff.h);
   assign q_right  = EDGE_BITS'(q_ff.x) + EDGE_BITS'(q_ff.w);
   assign q_bottom = EDGE_BITS'(q_ff.y) + EDGE_BITS'(q_ff.h);

   always_ff @(posedge clock) begin
      // intersection edges
      s1_left_ff   <= (p_ff.x > q_ff.x) ? EDGE_BITS'(p_ff.x) : EDGE_BITS'(q_ff.x);
      s1_top_ff    <= (p_ff.y > q_ff.y) ? EDGE_BITS'(p_ff.y) : EDGE_BITS'(q_ff.y);
      s1_right_ff  <= (p_right < q_right) ? p_right : q_right;
      s1_bottom_ff <= (p_bottom < q_bottom) ? p_bottom : q_bottom;
      s1_qw_ff     <= q_ff.w;
      s1_qh_ff     <= q_ff.h;
      // intersection sides and stored area
      s2_iw_ff <= (s1_right_ff > s1_left_ff) ? (s1_right_ff - s1_left_ff) : '0;
      s2_ih_ff <= (s1_bottom_ff > s1_top_ff) ? (s1_bottom_ff - s1_top_ff) : '0;
      s2_qa_ff <= AREA_BITS'(s1_qw_ff) * AREA_BITS'(s1_qh_ff);
      // intersection area
      s3_inter_ff <= INTER_BITS'(s2_iw_ff) * INTER_BITS'(s2_ih_ff);
      s3_qa_ff    <= s2_qa_ff;
      // union never exceeds the sum of the areas
      s4_union_ff   <= UNION_BITS'(pa_ff) + UNION_BITS'(s3_qa_ff)
                       - UNION_BITS'(s3_inter_ff);
      s4_inter_k_ff <= PROD_BITS'(s3_inter_ff) * PROD_BITS'(PERMILLE);
      // threshold side
      s5_thr_union_ff <= PROD_BITS'(thr_ff) * PROD_BITS'(s4_union_ff);
      s5_union_nz_ff  <= (s4_union_ff != '0);
      s5_inter_k_ff   <= s4_inter_k_ff;
   end

   assign sts.busy = |v_ff;
   assign sts.hit  = hit_ff;

endmodule

// ===== sv/gibs_ctrl.sv =====
// sequencer for the store scan, result register and kept count
module gibs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_frame_end,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gibs_pkg::rsp_type rsp_data,
   output gibs_pkg::cmd_type cmd,
   input  gibs_pkg::sts_type sts
);
   import gibs_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                frame_end_ff, frame_end_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                full;
   logic                keep;

   assign full = (count_ff == CNT_BITS'(MAX_KEPT));
   assign keep = !sts.hit;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      frame_end_in = frame_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd.load     = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.rd_addr  = idx_ff[IDX_BITS-1:0];
      cmd.wr_en    = 1'b0;
      cmd.wr_addr  = count_ff[IDX_BITS-1:0];
      req_ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               idx_in       = '0;
               frame_end_in = req_frame_end;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff != count_ff) begin
               cmd.rd_en = 1'b1;
               idx_in    = idx_ff + CNT_BITS'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.busy && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in      = 1'b1;
               rsp_in.keep       = keep;
               rsp_in.not_stored = keep && full;
               if (keep && !full) begin
                  cmd.wr_en = 1'b1;
                  count_in  = count_ff + CNT_BITS'(1);
               end
               if (frame_end_ff) begin
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      frame_end_ff <= frame_end_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/greedy_iou_box_suppression.sv =====
// top level of the greedy iou box suppression block
//
// usage:
//  - req channel: one beat per detection box (x, y, width, height, frame_end);
//    boxes of a frame arrive in order, frame_end marks the last one
//  - rsp channel: exactly one beat per box, keep and not_stored, in box order
//  - csr port: csr_wr_en with csr_wr_data loads the iou threshold in
//    thousandths (reset 300); write only while the block is idle
//  - each box is compared with every kept box of the frame, one stored box
//    per cycle through a six-stage overlap pipeline fed by the store's read port
//  - sequence: after a box is accepted the store's n kept boxes (up to 64) are read out
//    in turn, the pipeline drains, the result beat rises and the sequencer returns to
//    idle; only then is the next box taken, so boxes are handled one at a time
//  - a box is accepted while the previous result still waits in the output
//    register; if the receiver stalls, the block holds the finished result of
//    the following box until the register frees up
//  - reset empties the store and output register and restores the threshold;
//    the store contents need no clearing pass since only counted entries are read
//  - a full store still reports survivors as kept, with not_stored set
module greedy_iou_box_suppression (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  gibs_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output gibs_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [gibs_pkg::THR_BITS-1:0] csr_wr_data
);
   import gibs_pkg::*;

`include "greedy_iou_box_suppression_defines.svh"

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   gibs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_frame_end (req_data.frame_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .cmd           (cmd),
      .sts           (sts)
   );

   gibs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   // a new box only enters with the overlap pipeline empty
   `GIBS_ASSERT_SAME(a_accept_pipe_empty, req_valid && req_ready, !sts.busy, "busy at accept")
   // store write only once every compare of the box has finished
   `GIBS_ASSERT_SAME(a_write_after_drain, cmd.wr_en, !cmd.rd_en && !sts.busy, "early write")
   // every issued read shows up in the pipeline
   `GIBS_ASSERT_NEXT(a_read_tracked, cmd.rd_en, sts.busy, "issued compare lost")

endmodule

// ===== tb/sv/greedy_iou_box_suppression_tb.sv =====
// self-checking testbench for the greedy iou box suppression block
`timescale 1ns / 1ps

module greedy_iou_box_suppression_tb;
   import gibs_pkg::*;

   // worst case per box: full store plus pipeline, used when letting the block settle
   localparam int SETTLE_CYCLES = MAX_KEPT + 16;
   // several times the slowest correct run of roughly 1100 boxes, each with the largest gaps and a full store
   localparam int CYCLE_LIMIT   = 800_000;
   localparam int RANDOM_BOXES  = 1000;
   localparam int MAX_GAP       = 13;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [THR_BITS-1:0] csr_wr_data = '0;

   greedy_iou_box_suppression DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // suppression predictor: own copy of the threshold and kept boxes
   // ---------------------------------------------------------------
   logic [THR_BITS-1:0] iou_limit = THR_RESET;
   box_type             kept_store [MAX_KEPT];
   int                  kept_total = 0;

   // verdicts waiting for their rsp beat, oldest first
   rsp_type             pending_verdicts [$];

   // boxes sent in the current frame, source for near-duplicates
   req_type             frame_boxes [$];

   int  errors        = 0;
   int  cycles        = 0;
   int  boxes_sent    = 0;
   int  verdicts_seen = 0;
   int  kept_seen     = 0;
   int  dropped_seen  = 0;
   int  unstored_seen = 0;
   int  thr_writes    = 0;
   bit  no_gaps       = 1'b0;

   // exact integer iou test: inter * 1000 > threshold * union, zero union never overlaps
   function automatic bit iou_above(box_type a, box_type b);
      longint unsigned lft, top, rgt, bot, a_rgt, b_rgt, a_bot, b_bot;
      longint unsigned iw, ih, inter, uni;
      lft   = (a.x > b.x) ? longint'(a.x) : longint'(b.x);
      top   = (a.y > b.y) ? longint'(a.y) : longint'(b.y);
      // edge sums are one bit wider than the coordinates
      a_rgt = longint'(a.x) + longint'(a.w);
      b_rgt = longint'(b.x) + longint'(b.w);
      a_bot = longint'(a.y) + longint'(a.h);
      b_bot = longint'(b.y) + longint'(b.h);
      rgt   = (a_rgt < b_rgt) ? a_rgt : b_rgt;
      bot   = (a_bot < b_bot) ? a_bot : b_bot;
      iw    = (rgt > lft) ? rgt - lft : 0;
      ih    = (bot > top) ? bot - top : 0;
      inter = iw * ih;
      uni   = longint'(a.w) * longint'(a.h) + longint'(b.w) * longint'(b.h) - inter;
      if (uni == 0)
         return 1'b0;
      return inter * PERMILLE > longint'(iou_limit) * uni;
   endfunction

   // verdict for one box; updates the kept store and clears it on frame end
   function automatic rsp_type suppress_box(req_type r);
      box_type cand;
      rsp_type verdict;
      cand.x = r.box_x;
      cand.y = r.box_y;
      cand.w = r.box_width;
      cand.h = r.box_height;
      verdict.keep       = 1'b1;
      verdict.not_stored = 1'b0;
      for (int i = 0; i < kept_total; i++)
         if (iou_above(cand, kept_store[i]))
            verdict.keep = 1'b0;
      if (verdict.keep) begin
         if (kept_total < MAX_KEPT) begin
            kept_store[kept_total] = cand;
            kept_total++;
         end else begin
            // survivor of a full store: reported but not remembered
            verdict.not_stored = 1'b1;
         end
      end
      if (r.frame_end)
         kept_total = 0;
      return verdict;
   endfunction

   // ---------------------------------------------------------------
   // rsp side: random stall before each beat, none while no_gaps is set
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rsp_stall
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         hold = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         rsp_ready <= (hold == 0);
      end else if (hold != 0) begin
         hold--;
         rsp_ready <= (hold == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare every accepted rsp beat with the oldest waiting verdict
   always @(posedge clock) begin : verdict_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected rsp beat keep=%0b not_stored=%0b",
                     $time, rsp_data.keep, rsp_data.not_stored);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            verdicts_seen++;
            if (rsp_data.keep !== want.keep) begin
               $display("%0t: keep mismatch, expected %0b, got %0b",
                        $time, want.keep, rsp_data.keep);
               errors++;
            end
            if (rsp_data.not_stored !== want.not_stored) begin
               $display("%0t: not_stored mismatch, expected %0b, got %0b",
                        $time, want.not_stored, rsp_data.not_stored);
               errors++;
            end
            if (want.keep)
               kept_seen++;
            else
               dropped_seen++;
            if (want.not_stored)
               unstored_seen++;
         end
      end
   end

   // guard against a hung block
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                  $time, cycles, pending_verdicts.size());
         $display("[greedy_iou_box_suppression] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // shared stimulus tasks, all called on a rising edge
   // ---------------------------------------------------------------

   // one req beat after a random gap; valid stays up if the gap is zero
   task automatic send_box(input req_type b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (!req_ready);
      // beat accepted at this edge
      pending_verdicts = {pending_verdicts, suppress_box(b)};
      boxes_sent++;
      if (b.frame_end)
         frame_boxes.delete();
      else
         frame_boxes = {frame_boxes, b};
   endtask

   // hold off the sender until every verdict is back and the pipeline is empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_BITS-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      iou_limit = value;
      thr_writes++;
   endtask

   function automatic req_type mk_box(input int x, input int y, input int w, input int h,
                                      input bit last);
      req_type b;
      b.box_x      = COORD_BITS'(x);
      b.box_y      = COORD_BITS'(y);
      b.box_width  = COORD_BITS'(w);
      b.box_height = COORD_BITS'(h);
      b.frame_end  = last;
      return b;
   endfunction

   // random box; scatter_bias is the percentage of small scattered boxes
   function automatic req_type random_box(input int scatter_bias);
      req_type src;
      int      pick, dx, dy;
      pick = $urandom_range(0, 99);
      if (pick < scatter_bias)
         // small and spread out, mostly survives and fills the store
         return mk_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 150), $urandom_range(0, 150), 1'b0);
      if (frame_boxes.size() != 0 && pick < scatter_bias + (100 - scatter_bias) / 2) begin
         // near-duplicate of a box of this frame, exercises the threshold edge
         src = frame_boxes[$urandom_range(0, frame_boxes.size() - 1)];
         dx  = $urandom_range(0, src.box_width / 4 + 3);
         dy  = $urandom_range(0, src.box_height / 4 + 3);
         if ($urandom_range(0, 4) == 0)
            return src;
         return mk_box($urandom_range(0, 1) ? src.box_x + dx : src.box_x - dx,
                       $urandom_range(0, 1) ? src.box_y + dy : src.box_y - dy,
                       src.box_width + $urandom_range(0, 8) - 4,
                       src.box_height + $urandom_range(0, 8) - 4, 1'b0);
      end
      if (pick % 4 == 0)
         // width and height each zero at random, often a zero-area box
         return mk_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095),
                       $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095), 1'b0);
      // any bit pattern, large boxes that overlap a lot
      return mk_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0);
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // zero-area pairs, exact duplicates, the 300 permille edge and extreme coordinates
   task automatic test_default_threshold();
      send_box(mk_box(0, 0, 0, 0, 1'b0));               // all-zero box kept
      send_box(mk_box(0, 0, 0, 0, 1'b0));               // zero union with stored box: kept
      send_box(mk_box(100, 100, 100, 100, 1'b0));
      send_box(mk_box(100, 100, 100, 100, 1'b0));       // exact duplicate dropped
      send_box(mk_box(150, 100, 100, 100, 1'b0));       // iou 333 permille dropped
      send_box(mk_box(160, 100, 100, 100, 1'b0));       // iou 250 permille kept
      send_box(mk_box(4095, 4095, 4095, 4095, 1'b0));   // edge sums need the extra bit
      send_box(mk_box(4095, 4095, 4095, 4095, 1'b0));
      send_box(mk_box(4000, 4000, 4095, 4095, 1'b1));   // heavy overlap, closes the frame
      send_box(mk_box(4095, 4095, 4095, 4095, 1'b0));   // fresh frame, kept again
   endtask

   // threshold at 0, exactly 1000, above 1000, and just below 1000
   task automatic test_threshold_extremes();
      write_threshold(THR_BITS'(0));
      send_box(mk_box(0, 0, 10, 10, 1'b0));             // disjoint: zero inter never drops
      send_box(mk_box(9, 9, 10, 10, 1'b0));             // one pixel of overlap drops
      send_box(mk_box(10, 0, 10, 10, 1'b1));            // touching edge only
      write_threshold(THR_BITS'(1000));
      send_box(mk_box(500, 500, 20, 20, 1'b0));
      send_box(mk_box(500, 500, 20, 20, 1'b0));         // iou of exactly one is not above
      write_threshold(THR_BITS'(1023));
      send_box(mk_box(500, 500, 20, 20, 1'b1));         // nothing can be dropped
      write_threshold(THR_BITS'(999));
      send_box(mk_box(500, 500, 20, 20, 1'b0));
      send_box(mk_box(500, 500, 20, 20, 1'b1));
   endtask

   // disjoint boxes in a grid overflow the store, then duplicates and a new frame
   task automatic test_full_store();
      req_type first;
      write_threshold(THR_RESET);
      for (int i = 0; i < MAX_KEPT + 3; i++)
         send_box(mk_box((i % 8) * 450 + $urandom_range(0, 100),
                         (i / 8) * 450 + $urandom_range(0, 100),
                         $urandom_range(1, 300), $urandom_range(1, 300), 1'b0));
      first = frame_boxes[0];
      send_box(first);                                  // still checked against a full store
      send_box(frame_boxes[MAX_KEPT + 1]);              // unstored survivor leaves no trace
      first.frame_end = 1'b1;
      send_box(first);
      first.frame_end = 1'b0;
      send_box(first);                                  // store was emptied by the frame end
   endtask

   // frames of random content under a range of thresholds
   task automatic test_random_frames();
      logic [THR_BITS-1:0] thr_plan [8];
      int                  per_phase, frame_len, bias;
      req_type             b;
      thr_plan = '{THR_RESET, THR_BITS'($urandom_range(0, 1023)), THR_BITS'(0),
                   THR_BITS'(1000), THR_BITS'(1023), THR_BITS'($urandom_range(1, 999)),
                   THR_BITS'(700), THR_BITS'(50)};
      per_phase = RANDOM_BOXES / 8;
      for (int phase = 0; phase < 8; phase++) begin
         write_threshold(thr_plan[phase]);
         // one phase runs back to back on both sides
         no_gaps = (phase == 3);
         for (int n = 0; n < per_phase; n += frame_len) begin
            // mostly short frames; now and then a long one that fills the store
            if ($urandom_range(0, 7) == 0) begin
               frame_len = $urandom_range(MAX_KEPT - 4, MAX_KEPT + 26);
               bias      = 85;
            end else begin
               frame_len = $urandom_range(1, 24);
               bias      = 35;
            end
            for (int k = 0; k < frame_len; k++) begin
               b = random_box(bias);
               // a few frames are left open and run on into the next frame
               b.frame_end = (k == frame_len - 1) && ($urandom_range(0, 9) != 0);
               send_box(b);
            end
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_threshold();
      test_threshold_extremes();
      test_full_store();
      test_random_frames();

      // let the last verdicts drain; the cycle guard bounds this
      wait_idle();

      $display("%0d boxes sent, %0d verdicts checked under %0d threshold settings",
               boxes_sent, verdicts_seen, thr_writes);
      $display("%0d kept, %0d dropped, %0d kept with a full store",
               kept_seen, dropped_seen, unstored_seen);
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("[greedy_iou_box_suppression] OK");
      end else begin
         $display("%0d mismatches, %0d verdicts never arrived", errors,
                  pending_verdicts.size());
         $display("[greedy_iou_box_suppression] ERROR");
      end
      $finish;
   end

endmodule
